// File: rtl/core/pole_pkg.sv
// ============================================================================
// pole_pkg: shared types and constants for the positional ordered list engine
// Item layouts, operation and status codes, and cell chain control.
// ============================================================================
`default_nettype none

package pole_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] OP_GET           = 3'd0;
    localparam logic [2:0] OP_INSERT_BEFORE = 3'd1;
    localparam logic [2:0] OP_FIND          = 3'd2;
    localparam logic [2:0] OP_DELETE        = 3'd3;
    localparam logic [2:0] OP_SORTED_INSERT = 3'd4;
    localparam logic [2:0] OP_APPEND        = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [2:0]               operation;
        logic [7:0]               position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [7:0]               found_position;
        logic [7:0]               count;
    } out_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT
    } cell_mode_t;

    typedef enum logic [1:0] {
        CHAIN_HOLD,
        CHAIN_INSERT,
        CHAIN_DELETE
    } chain_mode_t;

    typedef struct packed {
        chain_mode_t              mode;
        logic [CNT_W-1:0]         target;
        logic signed [DATA_W-1:0] new_value;
    } chain_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/pole_cell.sv
// ============================================================================
// pole_cell: one list slot
// Holds one value, shifts from either neighbor or loads, and compares
// its value against the broadcast probe.
// ============================================================================
`default_nettype none

module pole_cell
    import pole_pkg::*;
(
    input  wire logic                     aclk,
    input  wire cell_mode_t               mode,
    input  wire logic signed [DATA_W-1:0] left_data,
    input  wire logic signed [DATA_W-1:0] right_data,
    input  wire logic signed [DATA_W-1:0] new_data,
    input  wire logic signed [DATA_W-1:0] probe,
    output logic signed [DATA_W-1:0]      data,
    output logic                          eq,
    output logic                          ge
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb begin
        unique case (mode)
            CELL_LOAD:       data_next = new_data;
            CELL_TAKE_LEFT:  data_next = left_data;
            CELL_TAKE_RIGHT: data_next = right_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign eq   = (data_reg == probe);
    assign ge   = (probe <= data_reg);

endmodule

`default_nettype wire

// File: rtl/core/pole_chain.sv
// ============================================================================
// pole_chain: row of list cells
// Decodes the broadcast insert or delete into per-cell moves and gathers
// the per-cell compare flags.
// ============================================================================
`default_nettype none

module pole_chain
    import pole_pkg::*;
(
    input  wire logic                          aclk,
    input  wire chain_ctrl_t                   ctrl,
    input  wire logic signed [DATA_W-1:0]      probe,
    output logic [CAPACITY-1:0][DATA_W-1:0]    data_vec,
    output logic [CAPACITY-1:0]                eq_vec,
    output logic [CAPACITY-1:0]                ge_vec
);

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++) begin : g_cell
            cell_mode_t               mode;
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;
            logic signed [DATA_W-1:0] own_d;

            assign own_d = data_vec[j];

            if (j == 0) begin : g_first
                assign left_d = own_d;
            end else begin : g_mid_l
                assign left_d = data_vec[j-1];
            end

            if (j == CAPACITY - 1) begin : g_last
                assign right_d = own_d;
            end else begin : g_mid_r
                assign right_d = data_vec[j+1];
            end

            always_comb begin
                unique case (ctrl.mode)
                    CHAIN_INSERT: begin
                        if (CNT_W'(j) == ctrl.target) begin
                            mode = CELL_LOAD;
                        end else if (CNT_W'(j) > ctrl.target) begin
                            mode = CELL_TAKE_LEFT;
                        end else begin
                            mode = CELL_HOLD;
                        end
                    end
                    CHAIN_DELETE: begin
                        if (CNT_W'(j) >= ctrl.target) begin
                            mode = CELL_TAKE_RIGHT;
                        end else begin
                            mode = CELL_HOLD;
                        end
                    end
                    default: mode = CELL_HOLD;
                endcase
            end

            pole_cell u_cell (
                .aclk       (aclk),
                .mode       (mode),
                .left_data  (left_d),
                .right_data (right_d),
                .new_data   (ctrl.new_value),
                .probe      (probe),
                .data       (data_vec[j]),
                .eq         (eq_vec[j]),
                .ge         (ge_vec[j])
            );
        end
    endgenerate

endmodule

`default_nettype wire

// File: rtl/core/positional_ordered_list_engine_top.sv
// ============================================================================
// positional_ordered_list_engine_top: bounded ordered list of signed values
// Get, insert before, find, delete, sorted insert and append on a shifting
// chain of cells with broadcast compare.
// ============================================================================
// Output: the result item is registered on the clock edge that accepts the input item.
// Throughput: one item per cycle while the output is not held; each operation
//   completes in its accepting cycle (shift, broadcast compare, priority pick).
// Reset: synchronous active-low aresetn empties the list and clears the
//   output valid; cell contents are left as they are and never read.
`default_nettype none

module positional_ordered_list_engine_top
    import pole_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    out_item_t                         m_item_reg;
    out_item_t                         m_item_next;

    logic                              accept;
    chain_ctrl_t                       ctrl;
    logic [CAPACITY-1:0][DATA_W-1:0]   data_vec;
    logic [CAPACITY-1:0]               eq_vec;
    logic [CAPACITY-1:0]               ge_vec;

    logic                              empty;
    logic                              full;
    logic                              pos_ok;
    logic [7:0]                        pos_m1;
    logic                              eq_hit;
    logic [CNT_W-1:0]                  eq_idx;
    logic [CNT_W-1:0]                  ge_idx;
    logic [CNT_W-1:0]                  cnt_after;
    logic [2:0]                        status;
    logic signed [DATA_W-1:0]          rd;
    logic [7:0]                        fpos;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    pole_chain u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .probe    (s_item.value),
        .data_vec (data_vec),
        .eq_vec   (eq_vec),
        .ge_vec   (ge_vec)
    );

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign pos_m1 = s_item.position - 8'd1;
    assign pos_ok = (s_item.position != 8'd0) && (s_item.position <= 8'(count_reg));

    // first valid match, first valid element >= value (count if none)
    always_comb begin
        eq_hit = 1'b0;
        eq_idx = '0;
        ge_idx = count_reg;
        for (int j = CAPACITY - 1; j >= 0; j--) begin
            if (CNT_W'(j) < count_reg) begin
                if (eq_vec[j]) begin
                    eq_hit = 1'b1;
                    eq_idx = CNT_W'(j);
                end
                if (ge_vec[j]) begin
                    ge_idx = CNT_W'(j);
                end
            end
        end
    end

    always_comb begin
        status         = ST_OK;
        rd             = '0;
        fpos           = '0;
        cnt_after      = count_reg;
        ctrl.mode      = CHAIN_HOLD;
        ctrl.target    = count_reg;
        ctrl.new_value = s_item.value;
        unique case (s_item.operation)
            OP_GET: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (!pos_ok) begin
                    status = ST_BADPOS;
                end else begin
                    rd = data_vec[pos_m1[SLOT_W-1:0]];
                end
            end
            OP_INSERT_BEFORE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (!pos_ok) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.mode   = CHAIN_INSERT;
                    ctrl.target = pos_m1[CNT_W-1:0];
                    cnt_after   = count_reg + CNT_W'(1);
                end
            end
            OP_FIND: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (eq_hit) begin
                    fpos = 8'(eq_idx) + 8'd1;
                end else begin
                    status = ST_NOTFOUND;
                end
            end
            OP_DELETE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (!pos_ok) begin
                    status = ST_BADPOS;
                end else begin
                    ctrl.mode   = CHAIN_DELETE;
                    ctrl.target = pos_m1[CNT_W-1:0];
                    cnt_after   = count_reg - CNT_W'(1);
                end
            end
            OP_SORTED_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.mode   = CHAIN_INSERT;
                    ctrl.target = ge_idx;
                    cnt_after   = count_reg + CNT_W'(1);
                end
            end
            OP_APPEND: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.mode   = CHAIN_INSERT;
                    ctrl.target = count_reg;
                    cnt_after   = count_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (!accept) begin
            ctrl.mode = CHAIN_HOLD;
        end
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            count_next                 = cnt_after;
            m_valid_next               = 1'b1;
            m_item_next.status         = status;
            m_item_next.read_value     = rd;
            m_item_next.found_position = fpos;
            m_item_next.count          = 8'(cnt_after);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire
